FILE: rtl/natt_pkg.sv
`default_nettype none
package natt_pkg;

  // Operation codes.
  localparam logic [1:0] OP_INBOUND  = 2'd0;
  localparam logic [1:0] OP_OUTBOUND = 2'd1;
  localparam logic [1:0] OP_ADD      = 2'd2;
  localparam logic [1:0] OP_DELETE   = 2'd3;

  // Protocol kinds.
  localparam logic [2:0] KIND_TCP       = 3'd0;
  localparam logic [2:0] KIND_UDP       = 3'd1;
  localparam logic [2:0] KIND_ICMP_ECHO = 3'd2;
  localparam logic [2:0] KIND_ICMP_ERR  = 3'd3;

  // Status codes.
  localparam logic [2:0] ST_TRANSLATED = 3'd0;
  localparam logic [2:0] ST_MISS       = 3'd1;
  localparam logic [2:0] ST_PASS       = 3'd2;
  localparam logic [2:0] ST_ADDED      = 3'd3;
  localparam logic [2:0] ST_REPLACED   = 3'd4;
  localparam logic [2:0] ST_DELETED    = 3'd5;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd6;
  localparam logic [2:0] ST_FULL       = 3'd7;

  localparam int unsigned InWidth  = 136;
  localparam int unsigned OutWidth = 120;

  // Ones'-complement end-around fold of a 17-bit sum.
  function automatic logic [15:0] oc_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // Incremental adjust: old + pos with end-around, then minus neg with borrow.
  function automatic logic [15:0] adjust(logic [15:0] old, logic [15:0] pos,
                                         logic [15:0] neg);
    logic [16:0] w;
    logic [16:0] d;
    w = {1'b0, old} + {1'b0, pos};
    w = {1'b0, w[15:0]} + {16'd0, w[16]};
    d = w - {1'b0, neg};
    if (d[16]) begin
      d = d - 17'd1;
    end
    return d[15:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/natt_sums.sv
`default_nettype none
// Builds the three stored complement sums of one address/port pair.
module natt_sums
  import natt_pkg::*;
(
  input  wire logic [31:0] addr_i,
  input  wire logic [15:0] port_i,
  output logic      [47:0] sums_o
);

  logic [15:0] ip_s;
  logic [15:0] pair_s;

  always_comb begin
    ip_s   = oc_add(addr_i[31:16], addr_i[15:0]);
    pair_s = oc_add(ip_s, port_i);
    sums_o = {~pair_s, ~ip_s, ~port_i};
  end

endmodule
`default_nettype wire

FILE: rtl/nat_translation_table_unit.sv
`default_nettype none
// Channel  Direction  Content
// s_axis   in         one operation (translate, add or delete)
// m_axis   out        one result per operation
//
// A priming step reads the first slot, the scan then compares one slot at a time on a
// shared compare unit, and an update step follows; the result is then offered, and
// the next item is taken only after the receiver has accepted that result.
// An add uses the first match or else the first free slot from the same scan.
// Reset clears the valid bits and the sequencer; stores are not cleared.
// A stalled result holds in the output register; no new item is taken then.
module nat_translation_table_unit
  import natt_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // op[1:0], proto_kind[4:2], key_addr[36:5], key_port[52:37], l4_sum[68:53],
  // ip_sum[84:69], inside_addr[116:85], inside_port[132:117], zero fill
  input  wire logic [InWidth-1:0]   s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // status[2:0], needs_full_sum[3], new_addr[35:4], new_port[51:36],
  // new_l4_sum[67:52], new_ip_sum[83:68], slot[87:84], hit_total[119:88]
  output logic      [OutWidth-1:0]  m_axis_tdata
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_EXEC = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [DEPTH-1:0] valid_q;
  logic [31:0] ia_mem [DEPTH];
  logic [15:0] ip_mem [DEPTH];
  logic [31:0] oa_mem [DEPTH];
  logic [15:0] op_mem [DEPTH];
  logic [47:0] is_mem [DEPTH];
  logic [47:0] os_mem [DEPTH];
  logic [31:0] hc_mem [DEPTH];

  logic [1:0]  op_q;
  logic [2:0]  kind_q;
  logic [31:0] kaddr_q, iaddr_q;
  logic [15:0] kport_q, l4_q, ips_q, iport_q;

  logic [IW-1:0] idx_q;
  logic          found_q, free_q;
  logic [IW-1:0] hit_idx_q, free_idx_q;

  // Registered read of the slot under scan.
  logic [31:0] rd_ia_q, rd_oa_q;
  logic [15:0] rd_ip_q, rd_op_q;
  logic        rd_v_q, rd_ok_q;
  logic [IW-1:0] rd_idx_q;
  logic        rd_last_q;

  logic [OutWidth-1:0] out_q;

  logic [47:0] ks_sums, is_sums;
  natt_sums u_ksums (.addr_i(kaddr_q), .port_i(kport_q), .sums_o(ks_sums));
  natt_sums u_isums (.addr_i(iaddr_q), .port_i(iport_q), .sums_o(is_sums));

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = out_q;

  // Shared compare unit on the registered slot.
  logic match;
  always_comb begin
    if (op_q == OP_OUTBOUND) begin
      match = rd_v_q && rd_ia_q == kaddr_q && rd_ip_q == kport_q;
    end else begin
      match = rd_v_q && rd_oa_q == kaddr_q && rd_op_q == kport_q;
    end
  end

  logic pass;
  assign pass = (op_q == OP_INBOUND || op_q == OP_OUTBOUND) && kind_q > KIND_ICMP_ERR;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (s_axis_tvalid) state_d = S_SCAN;
      S_SCAN: if (rd_ok_q && rd_last_q) state_d = S_EXEC;
      S_EXEC: state_d = S_OUT;
      S_OUT:  if (m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rd_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_ok_q <= (state_q == S_SCAN) && !(rd_ok_q && rd_last_q);
    end
  end

  // Result of the update step.
  logic [2:0]  r_st;
  logic        r_full;
  logic [31:0] r_addr, r_hits;
  logic [15:0] r_port, r_l4, r_ip;
  logic [IW-1:0] r_slot;
  logic        r_wr;
  logic [IW-1:0] w_idx;
  logic [47:0] to_s, from_s;
  always_comb begin
    r_st = ST_MISS; r_full = 1'b0; r_addr = kaddr_q; r_port = kport_q;
    r_l4 = l4_q; r_ip = ips_q; r_slot = '0; r_hits = '0; r_wr = 1'b0;
    w_idx = hit_idx_q;
    to_s = is_mem[hit_idx_q]; from_s = os_mem[hit_idx_q];
    if (op_q == OP_OUTBOUND) begin
      to_s = os_mem[hit_idx_q]; from_s = is_mem[hit_idx_q];
    end
    case (op_q)
      OP_INBOUND, OP_OUTBOUND: begin
        if (pass) begin
          r_st = ST_PASS;
        end else if (found_q) begin
          r_st = ST_TRANSLATED;
          r_slot = hit_idx_q;
          r_hits = hc_mem[hit_idx_q] + 32'd1;
          r_addr = (op_q == OP_INBOUND) ? ia_mem[hit_idx_q] : oa_mem[hit_idx_q];
          r_port = (op_q == OP_INBOUND) ? ip_mem[hit_idx_q] : op_mem[hit_idx_q];
          if (kind_q == KIND_TCP || kind_q == KIND_UDP) begin
            r_l4 = adjust(l4_q, to_s[47:32], from_s[47:32]);
          end else if (kind_q == KIND_ICMP_ECHO) begin
            r_l4 = adjust(l4_q, to_s[15:0], from_s[15:0]);
          end else begin
            r_full = 1'b1;
          end
          r_ip = adjust(ips_q, to_s[31:16], from_s[31:16]);
        end
      end
      OP_ADD: begin
        r_addr = '0; r_port = '0; r_l4 = '0; r_ip = '0;
        if (found_q) begin
          r_st = ST_REPLACED; r_wr = 1'b1;
        end else if (free_q) begin
          r_st = ST_ADDED; r_wr = 1'b1; w_idx = free_idx_q;
        end else begin
          r_st = ST_FULL;
        end
        if (r_wr) r_slot = w_idx;
      end
      default: begin
        r_addr = '0; r_port = '0; r_l4 = '0; r_ip = '0;
        if (found_q) begin
          r_st = ST_DELETED; r_slot = hit_idx_q;
        end else begin
          r_st = ST_NOT_FOUND;
        end
      end
    endcase
  end

  logic [3:0] slot4;
  always_comb begin
    slot4 = 4'(r_slot);
    if (IW < 4) slot4 = 4'({{(4){1'b0}}, r_slot});
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (state_q == S_EXEC) begin
      if (r_wr) valid_q[w_idx] <= 1'b1;
      if (op_q == OP_DELETE && found_q) valid_q[hit_idx_q] <= 1'b0;
    end
  end

  // Scan, stores and output register.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && s_axis_tvalid) begin
      op_q    <= s_axis_tdata[1:0];
      kind_q  <= s_axis_tdata[4:2];
      kaddr_q <= s_axis_tdata[36:5];
      kport_q <= s_axis_tdata[52:37];
      l4_q    <= s_axis_tdata[68:53];
      ips_q   <= s_axis_tdata[84:69];
      iaddr_q <= s_axis_tdata[116:85];
      iport_q <= s_axis_tdata[132:117];
      idx_q   <= '0;
      found_q <= 1'b0;
      free_q  <= 1'b0;
      hit_idx_q  <= '0;
      free_idx_q <= '0;
    end
    if (state_q == S_SCAN) begin
      rd_ia_q  <= ia_mem[idx_q];
      rd_ip_q  <= ip_mem[idx_q];
      rd_oa_q  <= oa_mem[idx_q];
      rd_op_q  <= op_mem[idx_q];
      rd_v_q   <= valid_q[idx_q];
      rd_idx_q <= idx_q;
      rd_last_q <= (32'(idx_q) == DEPTH - 1);
      if (32'(idx_q) != DEPTH - 1) idx_q <= idx_q + 1'b1;
      if (rd_ok_q) begin
        if (match && !found_q) begin
          found_q <= 1'b1; hit_idx_q <= rd_idx_q;
        end
        if (!rd_v_q && !free_q) begin
          free_q <= 1'b1; free_idx_q <= rd_idx_q;
        end
      end
    end
    if (state_q == S_EXEC) begin
      out_q <= {r_hits, slot4, r_ip, r_l4, r_port, r_addr, r_full, r_st};
      if (r_wr) begin
        oa_mem[w_idx] <= kaddr_q;
        op_mem[w_idx] <= kport_q;
        ia_mem[w_idx] <= iaddr_q;
        ip_mem[w_idx] <= iport_q;
        os_mem[w_idx] <= ks_sums;
        is_mem[w_idx] <= is_sums;
        hc_mem[w_idx] <= '0;
      end else if (r_st == ST_TRANSLATED) begin
        hc_mem[hit_idx_q] <= r_hits;
      end
    end
  end

endmodule
`default_nettype wire
